FILE: src/plki_pkg.sv
// Shared types and constants for the piecewise-linear key interpolator.
// No dependencies; every other file refers to this package by scoped names.
`default_nettype none

package plki_pkg;

	localparam int DATA_W        = 16;
	localparam int NUM_CH        = 3;
	localparam int CH_W          = $clog2(NUM_CH);
	localparam int MAX_KEYS_DEF  = 16;
	localparam int FRAC_BITS_DEF = 16;
	localparam int INDEX_W       = 4;
	localparam int KEY_COUNT_W   = 5;
	localparam logic [KEY_COUNT_W-1:0] KEY_COUNT_RST = 5'd1;

	localparam int APB_ADDR_W = 3;
	localparam int APB_DATA_W = 32;
	localparam int REG_IDX_W  = APB_ADDR_W - 2;
	localparam logic [REG_IDX_W-1:0] REG_KEY_COUNT = 1'b0;

	localparam logic ACT_WRITE  = 1'b0;
	localparam logic ACT_SAMPLE = 1'b1;

	typedef logic [DATA_W-1:0] word_t;
	typedef logic [NUM_CH-1:0][DATA_W-1:0] vals_t;

	typedef struct packed {
		word_t key;
		vals_t val;
	} entry_t;

	typedef enum logic [1:0] {
		MODE_SEARCH,
		MODE_CLAMP_FIRST,
		MODE_CLAMP_LAST,
		MODE_INTERP
	} mode_t;

	// Search packet that walks along the row of table cells
	typedef struct packed {
		logic   valid;
		mode_t  mode;
		word_t  f;
		entry_t prev;
		entry_t lo;
		entry_t hi;
	} pkt_t;

endpackage

`default_nettype wire

FILE: src/piecewise_linear_key_interpolator.sv
// Three-channel piecewise-linear interpolator over a table of up to MAX_KEYS keys.
// A write item (action 0) stores one entry and gives no result.
// A sample item (action 1) walks a search packet along the row of MAX_KEYS table
// cells, one cell per cycle; out_valid rises after the packet leaves the last cell and
// ST_HOLD for a clamped sample, and an interpolated one first also passes ST_DIV, the
// one-bit-per-cycle divider, and ST_LERP, the shared channel multiplier; ST_HOLD also
// waits for a full output register to drain.
// One sample is in flight at a time; the next item is taken once the result sits in
// the output register. key_count is written over the APB port at byte address 0.
// Depends on plki_pkg, plki_cell, plki_div and plki_lerp.
`default_nettype none

module piecewise_linear_key_interpolator #(
	parameter int MAX_KEYS  = plki_pkg::MAX_KEYS_DEF,
	parameter int FRAC_BITS = plki_pkg::FRAC_BITS_DEF
) (
	input  wire                              clk,
	input  wire                              arst_n,
	// configuration
	input  wire                              psel,
	input  wire                              penable,
	input  wire                              pwrite,
	input  wire [plki_pkg::APB_ADDR_W-1:0]   paddr,
	input  wire [plki_pkg::APB_DATA_W-1:0]   pwdata,
	output logic [plki_pkg::APB_DATA_W-1:0]  prdata,
	output logic                             pready,
	// input items
	input  wire                              in_valid,
	output logic                             in_ready,
	input  wire                              action,
	input  wire [plki_pkg::INDEX_W-1:0]      entry_index,
	input  wire [plki_pkg::DATA_W-1:0]       key_position,
	input  wire [plki_pkg::DATA_W-1:0]       value_x,
	input  wire [plki_pkg::DATA_W-1:0]       value_y,
	input  wire [plki_pkg::DATA_W-1:0]       value_z,
	input  wire [plki_pkg::DATA_W-1:0]       fraction,
	// result items
	output logic                             out_valid,
	input  wire                              out_ready,
	output logic [plki_pkg::DATA_W-1:0]      out_x,
	output logic [plki_pkg::DATA_W-1:0]      out_y,
	output logic [plki_pkg::DATA_W-1:0]      out_z
);

	localparam int IDX_W = $clog2(MAX_KEYS);

	typedef enum logic [4:0] {
		ST_IDLE   = 5'b00001,
		ST_SEARCH = 5'b00010,
		ST_DIV    = 5'b00100,
		ST_LERP   = 5'b01000,
		ST_HOLD   = 5'b10000
	} state_t;

	state_t                            state_q;
	logic [plki_pkg::KEY_COUNT_W-1:0]  key_count_q;
	logic                              out_valid_q;
	plki_pkg::vals_t                   out_q;
	plki_pkg::vals_t                   res_q;
	plki_pkg::vals_t                   lo_val_q;
	plki_pkg::vals_t                   hi_val_q;

	logic                              cfg_wr;
	logic                              in_fire;
	logic                              slot_free;
	int                                eff_cnt;
	logic [IDX_W-1:0]                  last_idx;
	plki_pkg::entry_t                  wr_entry;
	plki_pkg::pkt_t                    chain [MAX_KEYS+1];
	plki_pkg::pkt_t                    exit_pkt;
	logic [MAX_KEYS-1:0]               cell_wr;
	logic [MAX_KEYS-1:0]               cell_last;
	logic                              div_start;
	logic                              div_done;
	logic [FRAC_BITS-1:0]              div_quot;
	logic                              lerp_start;
	logic                              lerp_done;
	plki_pkg::vals_t                   lerp_res;

	assign pready = 1'b1;
	assign cfg_wr = psel && penable && pwrite && pready &&
		paddr[plki_pkg::APB_ADDR_W-1:2] == plki_pkg::REG_KEY_COUNT;

	always_comb begin
		prdata = '0;
		if (paddr[plki_pkg::APB_ADDR_W-1:2] == plki_pkg::REG_KEY_COUNT) begin
			prdata = plki_pkg::APB_DATA_W'(key_count_q);
		end
	end

	// zero counts as one, anything past the table as a full table
	always_comb begin
		eff_cnt = int'(key_count_q);
		if (eff_cnt == 0) begin
			eff_cnt = 1;
		end
		if (eff_cnt > MAX_KEYS) begin
			eff_cnt = MAX_KEYS;
		end
		last_idx = IDX_W'(eff_cnt - 1);
	end

	assign in_ready = state_q == ST_IDLE;
	assign in_fire = in_valid && in_ready;
	assign slot_free = !out_valid_q || out_ready;

	always_comb begin
		wr_entry.key = key_position;
		wr_entry.val = {value_z, value_y, value_x};
		chain[0] = '0;
		chain[0].valid = in_fire && action == plki_pkg::ACT_SAMPLE;
		chain[0].mode = plki_pkg::MODE_SEARCH;
		chain[0].f = fraction;
	end

	for (genvar i = 0; i < MAX_KEYS; i++) begin : g_cell
		assign cell_wr[i] = in_fire && action == plki_pkg::ACT_WRITE &&
			32'(entry_index) == 32'(i);
		assign cell_last[i] = last_idx == IDX_W'(i);

		plki_cell u_cell (
			.clk      (clk),
			.arst_n   (arst_n),
			.wr_en    (cell_wr[i]),
			.wr_entry (wr_entry),
			.is_first (i == 0),
			.is_last  (cell_last[i]),
			.pkt_in   (chain[i]),
			.pkt_out  (chain[i+1])
		);
	end

	assign exit_pkt = chain[MAX_KEYS];
	assign div_start = state_q == ST_SEARCH && exit_pkt.valid &&
		exit_pkt.mode == plki_pkg::MODE_INTERP;
	assign lerp_start = state_q == ST_DIV && div_done;

	plki_div #(
		.FRAC_BITS (FRAC_BITS)
	) u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (div_start),
		.num    (exit_pkt.f - exit_pkt.lo.key),
		.den    (exit_pkt.hi.key - exit_pkt.lo.key),
		.done   (div_done),
		.quot   (div_quot)
	);

	plki_lerp #(
		.FRAC_BITS (FRAC_BITS)
	) u_lerp (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (lerp_start),
		.t      (div_quot),
		.v0     (lo_val_q),
		.v1     (hi_val_q),
		.done   (lerp_done),
		.res    (lerp_res)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			key_count_q <= plki_pkg::KEY_COUNT_RST;
			out_valid_q <= 1'b0;
		end else begin
			if (cfg_wr) begin
				key_count_q <= pwdata[plki_pkg::KEY_COUNT_W-1:0];
			end
			// in HOLD the output register is refilled below
			if (out_valid_q && out_ready && state_q != ST_HOLD) begin
				out_valid_q <= 1'b0;
			end
			unique case (state_q)
				ST_IDLE: begin
					if (in_fire && action == plki_pkg::ACT_SAMPLE) begin
						state_q <= ST_SEARCH;
					end
				end
				ST_SEARCH: begin
					if (exit_pkt.valid) begin
						state_q <= div_start ? ST_DIV : ST_HOLD;
					end
				end
				ST_DIV: begin
					if (div_done) begin
						state_q <= ST_LERP;
					end
				end
				ST_LERP: begin
					if (lerp_done) begin
						state_q <= ST_HOLD;
					end
				end
				ST_HOLD: begin
					// wait for the output register to free up
					if (slot_free) begin
						out_valid_q <= 1'b1;
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == ST_SEARCH && exit_pkt.valid) begin
			res_q <= exit_pkt.lo.val;
			lo_val_q <= exit_pkt.lo.val;
			hi_val_q <= exit_pkt.hi.val;
		end
		if (state_q == ST_LERP && lerp_done) begin
			res_q <= lerp_res;
		end
		if (state_q == ST_HOLD && slot_free) begin
			out_q <= res_q;
		end
	end

	assign out_valid = out_valid_q;
	assign out_x = out_q[0];
	assign out_y = out_q[1];
	assign out_z = out_q[2];

endmodule

`default_nettype wire

FILE: src/plki_cell.sv
// One table cell: holds a single key entry and one stage of the search packet.
// Depends on plki_pkg.
`default_nettype none

module plki_cell (
	input  wire             clk,
	input  wire             arst_n,
	input  wire             wr_en,
	input  plki_pkg::entry_t wr_entry,
	input  wire             is_first,
	input  wire             is_last,
	input  plki_pkg::pkt_t  pkt_in,
	output plki_pkg::pkt_t  pkt_out
);

	plki_pkg::entry_t entry_q;
	plki_pkg::pkt_t   pkt_q;
	plki_pkg::pkt_t   nxt;

	always_comb begin
		nxt = pkt_in;
		nxt.prev = entry_q;
		if (pkt_in.valid) begin
			if (is_first) begin
				if (pkt_in.f <= entry_q.key) begin
					nxt.mode = plki_pkg::MODE_CLAMP_FIRST;
					nxt.lo = entry_q;
				end
			end else if (pkt_in.mode == plki_pkg::MODE_SEARCH &&
				pkt_in.prev.key <= pkt_in.f && pkt_in.f < entry_q.key) begin
				nxt.mode = plki_pkg::MODE_INTERP;
				nxt.lo = pkt_in.prev;
				nxt.hi = entry_q;
			end
			// last used key clamps if f reaches it or no interval found, unless first key clamped
			if (is_last && nxt.mode != plki_pkg::MODE_CLAMP_FIRST &&
				(pkt_in.f >= entry_q.key || nxt.mode == plki_pkg::MODE_SEARCH)) begin
				nxt.mode = plki_pkg::MODE_CLAMP_LAST;
				nxt.lo = entry_q;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (wr_en) begin
			entry_q <= wr_entry;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pkt_q <= '0;
		end else begin
			pkt_q <= nxt;
		end
	end

	assign pkt_out = pkt_q;

endmodule

`default_nettype wire

FILE: src/plki_div.sv
// Restoring divider, one quotient bit per cycle, for the interval position t.
// Depends on plki_pkg.
`default_nettype none

module plki_div #(
	parameter int FRAC_BITS = plki_pkg::FRAC_BITS_DEF
) (
	input  wire                   clk,
	input  wire                   arst_n,
	input  wire                   start,
	input  plki_pkg::word_t       num,
	input  plki_pkg::word_t       den,
	output logic                  done,
	output logic [FRAC_BITS-1:0]  quot
);

	localparam int CNT_W = $clog2(FRAC_BITS + 1);

	plki_pkg::word_t             rem_q;
	plki_pkg::word_t             den_q;
	logic [FRAC_BITS-1:0]        quot_q;
	logic [CNT_W-1:0]            cnt_q;
	logic                        busy_q;
	logic                        done_q;
	logic [plki_pkg::DATA_W:0]   shifted;
	logic [plki_pkg::DATA_W:0]   trial;
	logic                        take;

	always_comb begin
		shifted = {rem_q, 1'b0};
		trial = shifted - {1'b0, den_q};
		take = shifted >= {1'b0, den_q};
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q <= '0;
		end else begin
			done_q <= !start && busy_q && cnt_q == CNT_W'(1);
			if (start) begin
				busy_q <= 1'b1;
				cnt_q <= CNT_W'(FRAC_BITS);
			end else if (busy_q) begin
				cnt_q <= cnt_q - 1'b1;
				if (cnt_q == CNT_W'(1)) begin
					busy_q <= 1'b0;
				end
			end
		end
	end

	// remainder stays below the divisor, so the low DATA_W bits hold it
	always_ff @(posedge clk) begin
		if (start) begin
			rem_q <= num;
			den_q <= den;
			quot_q <= '0;
		end else if (busy_q) begin
			rem_q <= take ? trial[plki_pkg::DATA_W-1:0] : shifted[plki_pkg::DATA_W-1:0];
			quot_q <= {quot_q[FRAC_BITS-2:0], take};
		end
	end

	assign done = done_q;
	assign quot = quot_q;

endmodule

`default_nettype wire

FILE: src/plki_lerp.sv
// Channel blend: one shared multiplier, one channel per cycle, then add or subtract.
// Depends on plki_pkg.
`default_nettype none

module plki_lerp #(
	parameter int FRAC_BITS = plki_pkg::FRAC_BITS_DEF
) (
	input  wire                  clk,
	input  wire                  arst_n,
	input  wire                  start,
	input  wire [FRAC_BITS-1:0]  t,
	input  plki_pkg::vals_t      v0,
	input  plki_pkg::vals_t      v1,
	output logic                 done,
	output plki_pkg::vals_t      res
);

	localparam int PROD_W = FRAC_BITS + plki_pkg::DATA_W;

	logic [plki_pkg::CH_W-1:0] ch_q;
	logic                      run_q;
	logic                      valid_s1;
	logic                      last_s1;
	logic                      done_q;
	logic [plki_pkg::CH_W-1:0] ch_s1;
	logic                      down_s1;
	plki_pkg::word_t           v0_s1;
	logic [PROD_W-1:0]         prod_s1;
	plki_pkg::vals_t           res_q;

	plki_pkg::word_t   a;
	plki_pkg::word_t   b;
	logic              down;
	plki_pkg::word_t   diff;
	logic [PROD_W-1:0] prod;
	plki_pkg::word_t   q;
	plki_pkg::word_t   step;

	always_comb begin
		a = v0[ch_q];
		b = v1[ch_q];
		down = b < a;
		diff = down ? a - b : b - a;
		prod = PROD_W'(t) * PROD_W'(diff);
		// falling segment rounds the step up so the result floors
		q = prod_s1[PROD_W-1:FRAC_BITS] +
			plki_pkg::DATA_W'(down_s1 && (prod_s1[FRAC_BITS-1:0] != '0));
		step = down_s1 ? v0_s1 - q : v0_s1 + q;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			run_q <= 1'b0;
			ch_q <= '0;
			valid_s1 <= 1'b0;
			last_s1 <= 1'b0;
			done_q <= 1'b0;
		end else begin
			if (start) begin
				run_q <= 1'b1;
				ch_q <= '0;
			end else if (run_q) begin
				ch_q <= ch_q + 1'b1;
				if (ch_q == plki_pkg::CH_W'(plki_pkg::NUM_CH - 1)) begin
					run_q <= 1'b0;
				end
			end
			valid_s1 <= run_q;
			last_s1 <= run_q && ch_q == plki_pkg::CH_W'(plki_pkg::NUM_CH - 1);
			done_q <= valid_s1 && last_s1;
		end
	end

	always_ff @(posedge clk) begin
		ch_s1 <= ch_q;
		down_s1 <= down;
		v0_s1 <= a;
		prod_s1 <= prod;
		if (valid_s1) begin
			res_q[ch_s1] <= step;
		end
	end

	assign done = done_q;
	assign res = res_q;

endmodule

`default_nettype wire
